// ===== hdl/ole_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list engine package
// Widths, operation and status codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int FUNC_W     = 4;
	localparam int POS_W      = 5;
	localparam int STATUS_W   = 3;
	localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [POS_W-1:0]             pos_t;
	typedef logic [CMP_W-1:0]             cmp_t;
	typedef logic [FUNC_W-1:0]            func_t;
	typedef logic [STATUS_W-1:0]          status_t;
	typedef logic signed [DATA_WIDTH-1:0] data_t;

	localparam func_t FN_INS_POS   = 4'd0;
	localparam func_t FN_DEL_POS   = 4'd1;
	localparam func_t FN_DEL_KEY   = 4'd2;
	localparam func_t FN_REVERSE   = 4'd3;
	localparam func_t FN_INS_FRONT = 4'd4;
	localparam func_t FN_INS_REAR  = 4'd5;
	localparam func_t FN_DEL_FRONT = 4'd6;
	localparam func_t FN_DEL_REAR  = 4'd7;
	localparam func_t FN_READ      = 4'd8;

	localparam status_t ST_OK     = 3'd0;
	localparam status_t ST_EMPTY  = 3'd1;
	localparam status_t ST_BADPOS = 3'd2;
	localparam status_t ST_NOKEY  = 3'd3;
	localparam status_t ST_FULL   = 3'd4;

	typedef enum logic [2:0] {
		CUR_HOLD, CUR_ZERO, CUR_COUNT, CUR_POS, CUR_LAST, CUR_INC, CUR_DEC
	} cur_sel_t;

	typedef enum logic [2:0] {
		TGT_HOLD, TGT_POS, TGT_ZERO, TGT_COUNT, TGT_LAST, TGT_DEC
	} tgt_sel_t;

	typedef enum logic [2:0] {
		RA_CUR, RA_CUR_M1, RA_CUR_P1, RA_TGT, RA_POS
	} rd_sel_t;

	typedef enum logic {
		WA_CUR, WA_TGT
	} wa_sel_t;

	typedef enum logic [1:0] {
		WD_RAM, WD_VALUE, WD_TMP
	} wd_sel_t;

	typedef struct packed {
		logic     req_load;
		cur_sel_t cur_sel;
		tgt_sel_t tgt_sel;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wa_sel_t  wa_sel;
		wd_sel_t  wd_sel;
		logic     tmp_load;
		logic     rdv_load;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     stat_load;
		status_t  stat_code;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  cnt_zero;
		logic  cnt_full;
		logic  ins_pos_bad;
		logic  pos_bad;
		logic  cur_gt_tgt;
		logic  cur_p1_lt_cnt;
		logic  cur_lt_cnt;
		logic  cur_lt_tgt;
		logic  key_match;
		logic  out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/ordered_list_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list engine
// Keeps an ordered list of signed values with a count and serves insert,
// delete, key delete, reverse and read requests, one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time, and every entry move goes through the
// entry store, one access per cycle. A request that fails its checks, or a
// function code that does nothing, goes from decode straight to the result.
// A read captures the entry at the given position. An insert shifts each
// entry at or above the insert index up by one place and writes the value;
// a delete shifts each later entry down by one; a key delete scans from the
// front for a match and then shifts down as a delete does; a reverse swaps
// entries in pairs from both ends inward. The store needs no clearing after
// reset. A new request is taken once the previous one has placed its result
// in the output register, even while that result still waits to be taken.
module ordered_list_engine_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ole_pkg::func_t   func,
	input  ole_pkg::pos_t    position,
	input  ole_pkg::data_t   value,
	output logic             out_valid,
	input  logic             out_stall,
	output ole_pkg::status_t status,
	output ole_pkg::cnt_t    entry_count,
	output ole_pkg::data_t   read_value
);

	ole_pkg::cmd_t cmd;
	ole_pkg::sts_t sts;

	ole_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	ole_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.position    (position),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_count (entry_count),
		.read_value  (read_value)
	);

endmodule
`default_nettype wire

// ===== hdl/ole_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ole_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list engine datapath
// Holds the request, the entry count, the cursor and target pointers, the
// entry store and the result register, and acts on controller commands.
// ----------------------------------------------------------------------------
module ole_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ole_pkg::func_t        func,
	input  ole_pkg::pos_t         position,
	input  ole_pkg::data_t        value,
	input  ole_pkg::cmd_t         cmd,
	output ole_pkg::sts_t         sts,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ole_pkg::status_t      status,
	output ole_pkg::cnt_t         entry_count,
	output ole_pkg::data_t        read_value
);

	ole_pkg::func_t   func_q;
	ole_pkg::pos_t    pos_q;
	ole_pkg::data_t   value_q;
	ole_pkg::cnt_t    cur_q;
	ole_pkg::cnt_t    tgt_q;
	ole_pkg::cnt_t    cnt_q;
	ole_pkg::data_t   tmp_q;
	ole_pkg::data_t   rdv_q;
	ole_pkg::status_t stat_q;
	logic             out_valid_q;
	ole_pkg::status_t out_status_q;
	ole_pkg::cnt_t    out_count_q;
	ole_pkg::data_t   out_rdv_q;

	ole_pkg::pos_t    pos_idx;
	ole_pkg::cnt_t    cnt_last;
	ole_pkg::cnt_t    wr_ptr;
	ole_pkg::addr_t   raddr;
	ole_pkg::data_t   wdata;
	logic [ole_pkg::DATA_WIDTH-1:0] ram_rdata;
	ole_pkg::data_t   rdata;

	assign pos_idx  = (pos_q == '0) ? '0 : pos_q - ole_pkg::pos_t'(1);
	assign cnt_last = cnt_q - ole_pkg::cnt_t'(1);
	assign rdata    = ole_pkg::data_t'(ram_rdata);

	always_comb begin
		unique case (cmd.rd_sel)
			ole_pkg::RA_CUR:    raddr = ole_pkg::addr_t'(cur_q);
			ole_pkg::RA_CUR_M1: raddr = ole_pkg::addr_t'(cur_q - ole_pkg::cnt_t'(1));
			ole_pkg::RA_CUR_P1: raddr = ole_pkg::addr_t'(cur_q + ole_pkg::cnt_t'(1));
			ole_pkg::RA_TGT:    raddr = ole_pkg::addr_t'(tgt_q);
			ole_pkg::RA_POS:    raddr = ole_pkg::addr_t'(pos_idx);
			default:            raddr = ole_pkg::addr_t'(cur_q);
		endcase
	end

	assign wr_ptr = (cmd.wa_sel == ole_pkg::WA_TGT) ? tgt_q : cur_q;

	always_comb begin
		unique case (cmd.wd_sel)
			ole_pkg::WD_RAM:   wdata = rdata;
			ole_pkg::WD_VALUE: wdata = value_q;
			ole_pkg::WD_TMP:   wdata = tmp_q;
			default:           wdata = rdata;
		endcase
	end

	ole_ram #(
		.WIDTH (ole_pkg::DATA_WIDTH),
		.DEPTH (ole_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (ole_pkg::addr_t'(wr_ptr)),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + ole_pkg::cnt_t'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_last;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			func_q  <= func;
			pos_q   <= position;
			value_q <= value;
			rdv_q   <= '0;
		end else if (cmd.rdv_load) begin
			rdv_q <= rdata;
		end
		unique case (cmd.cur_sel)
			ole_pkg::CUR_HOLD:  cur_q <= cur_q;
			ole_pkg::CUR_ZERO:  cur_q <= '0;
			ole_pkg::CUR_COUNT: cur_q <= cnt_q;
			ole_pkg::CUR_POS:   cur_q <= ole_pkg::cnt_t'(pos_idx);
			ole_pkg::CUR_LAST:  cur_q <= cnt_last;
			ole_pkg::CUR_INC:   cur_q <= cur_q + ole_pkg::cnt_t'(1);
			ole_pkg::CUR_DEC:   cur_q <= cur_q - ole_pkg::cnt_t'(1);
			default:            cur_q <= cur_q;
		endcase
		unique case (cmd.tgt_sel)
			ole_pkg::TGT_HOLD:  tgt_q <= tgt_q;
			ole_pkg::TGT_POS:   tgt_q <= ole_pkg::cnt_t'(pos_idx);
			ole_pkg::TGT_ZERO:  tgt_q <= '0;
			ole_pkg::TGT_COUNT: tgt_q <= cnt_q;
			ole_pkg::TGT_LAST:  tgt_q <= cnt_last;
			ole_pkg::TGT_DEC:   tgt_q <= tgt_q - ole_pkg::cnt_t'(1);
			default:            tgt_q <= tgt_q;
		endcase
		if (cmd.tmp_load) begin
			tmp_q <= rdata;
		end
		if (cmd.stat_load) begin
			stat_q <= cmd.stat_code;
		end
		if (cmd.out_load) begin
			out_status_q <= stat_q;
			out_count_q  <= cnt_q;
			out_rdv_q    <= rdv_q;
		end
	end

	always_comb begin
		sts.func          = func_q;
		sts.cnt_zero      = (cnt_q == '0);
		sts.cnt_full      = (cnt_q >= ole_pkg::cnt_t'(ole_pkg::CAPACITY));
		sts.ins_pos_bad   = ole_pkg::cmp_t'(pos_q) > (ole_pkg::cmp_t'(cnt_q) + ole_pkg::cmp_t'(1));
		sts.pos_bad       = ole_pkg::cmp_t'(pos_q) > ole_pkg::cmp_t'(cnt_q);
		sts.cur_gt_tgt    = (cur_q > tgt_q);
		sts.cur_p1_lt_cnt = (ole_pkg::cmp_t'(cur_q) + ole_pkg::cmp_t'(1)) < ole_pkg::cmp_t'(cnt_q);
		sts.cur_lt_cnt    = (cur_q < cnt_q);
		sts.cur_lt_tgt    = (cur_q < tgt_q);
		sts.key_match     = (rdata == value_q);
		sts.out_busy      = out_valid_q && out_stall;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;
	assign read_value  = out_rdv_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ole_pkg::cnt_t'(ole_pkg::CAPACITY))
		else $error("Entry count exceeds the capacity.");

	a_cnt_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (cnt_q < ole_pkg::cnt_t'(ole_pkg::CAPACITY)) && !cmd.cnt_dec)
		else $error("Entry count incremented on a full list.");

	a_cnt_dec_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (cnt_q != '0))
		else $error("Entry count decremented on an empty list.");

	a_wr_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (wr_ptr < ole_pkg::cnt_t'(ole_pkg::CAPACITY)) && (wr_ptr <= cnt_q))
		else $error("Store write outside the occupied range.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("Pending result overwritten.");
`endif

endmodule
`default_nettype wire

// ===== hdl/ole_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list engine controller
// Decodes each request and sequences the shift, search, swap and read
// steps of the datapath, one store access per cycle.
// ----------------------------------------------------------------------------
module ole_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output ole_pkg::cmd_t cmd,
	input  ole_pkg::sts_t sts
);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_DECODE   = 14'b00000000000010,
		S_INS_CHK  = 14'b00000000000100,
		S_INS_MOVE = 14'b00000000001000,
		S_REM_CHK  = 14'b00000000010000,
		S_REM_MOVE = 14'b00000000100000,
		S_KEY_RD   = 14'b00000001000000,
		S_KEY_CMP  = 14'b00000010000000,
		S_REV_CHK  = 14'b00000100000000,
		S_REV_RDB  = 14'b00001000000000,
		S_REV_WRA  = 14'b00010000000000,
		S_REV_WRB  = 14'b00100000000000,
		S_RD_CAP   = 14'b01000000000000,
		S_DONE     = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.stat_load = 1'b1;
				cmd.stat_code = ole_pkg::ST_OK;
				state_d       = S_DONE;
				unique case (sts.func)
					ole_pkg::FN_INS_POS: begin
						if (sts.ins_pos_bad) begin
							cmd.stat_code = ole_pkg::ST_BADPOS;
						end else if (sts.cnt_full) begin
							cmd.stat_code = ole_pkg::ST_FULL;
						end else begin
							cmd.cur_sel = ole_pkg::CUR_COUNT;
							cmd.tgt_sel = ole_pkg::TGT_POS;
							state_d     = S_INS_CHK;
						end
					end
					ole_pkg::FN_INS_FRONT: begin
						if (sts.cnt_full) begin
							cmd.stat_code = ole_pkg::ST_FULL;
						end else begin
							cmd.cur_sel = ole_pkg::CUR_COUNT;
							cmd.tgt_sel = ole_pkg::TGT_ZERO;
							state_d     = S_INS_CHK;
						end
					end
					ole_pkg::FN_INS_REAR: begin
						if (sts.cnt_full) begin
							cmd.stat_code = ole_pkg::ST_FULL;
						end else begin
							cmd.cur_sel = ole_pkg::CUR_COUNT;
							cmd.tgt_sel = ole_pkg::TGT_COUNT;
							state_d     = S_INS_CHK;
						end
					end
					ole_pkg::FN_DEL_POS: begin
						if (sts.cnt_zero) begin
							cmd.stat_code = ole_pkg::ST_EMPTY;
						end else if (sts.pos_bad) begin
							cmd.stat_code = ole_pkg::ST_BADPOS;
						end else begin
							cmd.cur_sel = ole_pkg::CUR_POS;
							state_d     = S_REM_CHK;
						end
					end
					ole_pkg::FN_DEL_KEY: begin
						if (sts.cnt_zero) begin
							cmd.stat_code = ole_pkg::ST_EMPTY;
						end else begin
							cmd.cur_sel = ole_pkg::CUR_ZERO;
							state_d     = S_KEY_RD;
						end
					end
					ole_pkg::FN_REVERSE: begin
						if (sts.cnt_zero) begin
							cmd.stat_code = ole_pkg::ST_EMPTY;
						end else begin
							cmd.cur_sel = ole_pkg::CUR_ZERO;
							cmd.tgt_sel = ole_pkg::TGT_LAST;
							state_d     = S_REV_CHK;
						end
					end
					ole_pkg::FN_DEL_FRONT: begin
						if (sts.cnt_zero) begin
							cmd.stat_code = ole_pkg::ST_EMPTY;
						end else begin
							cmd.cur_sel = ole_pkg::CUR_ZERO;
							state_d     = S_REM_CHK;
						end
					end
					ole_pkg::FN_DEL_REAR: begin
						if (sts.cnt_zero) begin
							cmd.stat_code = ole_pkg::ST_EMPTY;
						end else begin
							cmd.cur_sel = ole_pkg::CUR_LAST;
							state_d     = S_REM_CHK;
						end
					end
					ole_pkg::FN_READ: begin
						if (sts.cnt_zero) begin
							cmd.stat_code = ole_pkg::ST_EMPTY;
						end else if (sts.pos_bad) begin
							cmd.stat_code = ole_pkg::ST_BADPOS;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = ole_pkg::RA_POS;
							state_d    = S_RD_CAP;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_INS_CHK: begin
				if (sts.cur_gt_tgt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ole_pkg::RA_CUR_M1;
					state_d    = S_INS_MOVE;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wa_sel  = ole_pkg::WA_CUR;
					cmd.wd_sel  = ole_pkg::WD_VALUE;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_INS_MOVE: begin
				cmd.wr_en   = 1'b1;
				cmd.wa_sel  = ole_pkg::WA_CUR;
				cmd.wd_sel  = ole_pkg::WD_RAM;
				cmd.cur_sel = ole_pkg::CUR_DEC;
				state_d     = S_INS_CHK;
			end
			S_REM_CHK: begin
				if (sts.cur_p1_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ole_pkg::RA_CUR_P1;
					state_d    = S_REM_MOVE;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_REM_MOVE: begin
				cmd.wr_en   = 1'b1;
				cmd.wa_sel  = ole_pkg::WA_CUR;
				cmd.wd_sel  = ole_pkg::WD_RAM;
				cmd.cur_sel = ole_pkg::CUR_INC;
				state_d     = S_REM_CHK;
			end
			S_KEY_RD: begin
				if (sts.cur_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ole_pkg::RA_CUR;
					state_d    = S_KEY_CMP;
				end else begin
					cmd.stat_load = 1'b1;
					cmd.stat_code = ole_pkg::ST_NOKEY;
					state_d       = S_DONE;
				end
			end
			S_KEY_CMP: begin
				if (sts.key_match) begin
					state_d = S_REM_CHK;
				end else begin
					cmd.cur_sel = ole_pkg::CUR_INC;
					state_d     = S_KEY_RD;
				end
			end
			S_REV_CHK: begin
				if (sts.cur_lt_tgt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ole_pkg::RA_CUR;
					state_d    = S_REV_RDB;
				end else begin
					state_d = S_DONE;
				end
			end
			S_REV_RDB: begin
				cmd.tmp_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = ole_pkg::RA_TGT;
				state_d      = S_REV_WRA;
			end
			S_REV_WRA: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = ole_pkg::WA_CUR;
				cmd.wd_sel = ole_pkg::WD_RAM;
				state_d    = S_REV_WRB;
			end
			S_REV_WRB: begin
				cmd.wr_en   = 1'b1;
				cmd.wa_sel  = ole_pkg::WA_TGT;
				cmd.wd_sel  = ole_pkg::WD_TMP;
				cmd.cur_sel = ole_pkg::CUR_INC;
				cmd.tgt_sel = ole_pkg::TGT_DEC;
				state_d     = S_REV_CHK;
			end
			S_RD_CAP: begin
				cmd.rdv_load = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire
